// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
// Include-guarded; holds only macro definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cond) else $error(msg);
// Same check, but active during reset too.
`define CHK_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) cond) else $error(msg);
`endif

// ----- hdl/hqs_pkg.sv -----
// Package for the quicksort sorter: payload structs, sizes, and the signed compare.
// Used by every module of the block; no dependencies.
package hqs_pkg;
  localparam int MaxItems = 64;
  localparam int AW = $clog2(MaxItems);
  localparam int CW = AW + 1;
  localparam int StackDepth = 64;
  localparam int SW = $clog2(StackDepth);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               final_res;
    logic               truncated;
  } out_item_t;

  // Handshake between the sequencer and the item store
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;
  } mem_req_t;

  function automatic logic lt(input logic [31:0] a, input logic [31:0] b);
    lt = $signed(a) < $signed(b);
  endfunction
endpackage

// ----- hdl/hqs_store.sv -----
// Item store: one write port, one registered read port.
// Depends on hqs_pkg.
module hqs_store (
  input  logic                   clk,
  input  hqs_pkg::mem_req_t      req,
  output logic [31:0]            rd_data
);
  logic [31:0] mem [hqs_pkg::MaxItems];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end
endmodule

// ----- hdl/hqs_stack.sv -----
// Range stack memory: pending {lo, hi} pairs, registered read.
// Depends on hqs_pkg.
module hqs_stack (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [hqs_pkg::SW-1:0]        wr_addr,
  input  logic [2*hqs_pkg::AW-1:0]      wr_data,
  input  logic [hqs_pkg::SW-1:0]        rd_addr,
  output logic [2*hqs_pkg::AW-1:0]      rd_data
);
  logic [2*hqs_pkg::AW-1:0] mem [hqs_pkg::StackDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- hdl/hoare_quicksort_sorter_unit.sv -----
// Channel   Direction  Payload                            Handshake
// in        input      value, last                        in_valid / in_stall
// out       output     sorted_value, final_res, truncated out_valid / out_stall
// Loading accepts one item per cycle. On last, the sort runs on the store memory
// (one read port): compares read in S_IRD/S_JRD and test in S_IW/S_JW, swaps
// write in S_SWAP1 then S_SWAP2. Results go out one per cycle unless out_stall.
// Reset clears the count, flags and sequencer; the memories need no clearing.
// in_stall is high from the last item until its final result is taken.
// Depends on hqs_pkg, hqs_store, hqs_stack.
module hoare_quicksort_sorter_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hqs_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hqs_pkg::out_item_t   out_item
);
  localparam int AW = hqs_pkg::AW;
  localparam int CW = hqs_pkg::CW;
  localparam int SW = hqs_pkg::SW;

  typedef enum logic [13:0] {
    S_LOAD   = 14'b00000000000001,
    S_POP    = 14'b00000000000010,
    S_POPW   = 14'b00000000000100,
    S_PIVR   = 14'b00000000001000,
    S_PIVW   = 14'b00000000010000,
    S_IRD    = 14'b00000000100000,
    S_IW     = 14'b00000001000000,
    S_JRD    = 14'b00000010000000,
    S_JW     = 14'b00000100000000,
    S_SWAP1  = 14'b00001000000000,
    S_SWAP2  = 14'b00010000000000,
    S_PUSH   = 14'b00100000000000,
    S_EMRD   = 14'b01000000000000,
    S_EMIT   = 14'b10000000000000
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic          ovf;
  logic [AW-1:0] lo, hi, i, j;
  logic [31:0]   pivot, vi;
  logic [SW:0]   sp;
  logic [AW-1:0] ek;
  logic [31:0]   rd_data;
  logic [2*AW-1:0] st_rd;
  hqs_pkg::mem_req_t req;
  logic          st_we;
  logic [SW-1:0] st_waddr, st_raddr;
  logic [2*AW-1:0] st_wdata;
  logic          push_left_done;

  hqs_store u_store (.clk(clk), .req(req), .rd_data(rd_data));
  hqs_stack u_stack (.clk(clk), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
                     .rd_addr(st_raddr), .rd_data(st_rd));

  assign in_stall = (state != S_LOAD);

  // Memory request decode
  always_comb begin
    req = '0;
    req.rd_addr = i;
    unique case (state)
      S_LOAD:  begin
        req.wr_en   = in_valid && (count < CW'(hqs_pkg::MaxItems));
        req.wr_addr = count[AW-1:0];
        req.wr_data = in_item.value;
      end
      S_POPW:  req.rd_addr = st_rd[2*AW-1:AW];
      S_IRD, S_IW: req.rd_addr = i;
      S_JRD, S_JW: req.rd_addr = j;
      S_SWAP1: begin
        req.wr_en = 1'b1; req.wr_addr = i; req.wr_data = rd_data;
      end
      S_SWAP2: begin
        req.wr_en = 1'b1; req.wr_addr = j; req.wr_data = vi;
      end
      S_EMRD, S_EMIT: req.rd_addr = (state == S_EMIT && !out_stall) ? ek + 1'b1 : ek;
      default: req.rd_addr = i;
    endcase
  end

  // Stack pushes: initial {0, last index} while loading; left {lo, j} then right {j+1, hi}
  always_comb begin
    st_we    = 1'b0;
    st_waddr = sp[SW-1:0];
    st_wdata = '0;
    st_raddr = SW'(sp - 1'b1);
    if (state == S_LOAD) begin
      st_we    = 1'b1;
      st_waddr = '0;
      if (!(in_valid && count < CW'(hqs_pkg::MaxItems))) st_wdata = {AW'(0), AW'(count - 1'b1)};
      else st_wdata = {AW'(0), count[AW-1:0]};
    end else if (state == S_PUSH) begin
      if (!push_left_done) begin
        st_we = (lo < j) && (sp < (SW+1)'(hqs_pkg::StackDepth));
        st_wdata = {lo, j};
      end else begin
        st_we = (AW'(j + 1'b1) < hi) && (j != hi) &&
                (sp < (SW+1)'(hqs_pkg::StackDepth));
        st_wdata = {AW'(j + 1'b1), hi};
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      ovf   <= 1'b0;
      sp    <= '0;
      out_valid <= 1'b0;
      push_left_done <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (in_valid) begin
          if (count < CW'(hqs_pkg::MaxItems)) count <= count + 1'b1;
          else ovf <= 1'b1;
          if (in_item.last) begin
            // sort needs at least two stored values
            sp <= ((count < CW'(hqs_pkg::MaxItems)) ? count + 1'b1 : count) >= CW'(2)
                  ? (SW+1)'(1) : '0;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (sp == '0) begin
            ek <= '0;
            state <= S_EMRD;
          end else begin
            sp <= sp - 1'b1;
            state <= S_POPW;
          end
        end
        S_POPW: begin
          lo <= st_rd[2*AW-1:AW];
          hi <= st_rd[AW-1:0];
          i  <= st_rd[2*AW-1:AW];
          j  <= st_rd[AW-1:0];
          state <= S_PIVR;
        end
        S_PIVR: begin
          pivot <= rd_data;
          state <= S_IRD;
        end
        S_PIVW: state <= S_IRD;
        S_IRD: state <= S_IW;
        S_IW: begin
          if (i < hi && hqs_pkg::lt(rd_data, pivot)) begin
            i <= i + 1'b1;
            state <= S_IRD;
          end else begin
            vi <= rd_data;
            state <= S_JRD;
          end
        end
        S_JRD: state <= S_JW;
        S_JW: begin
          if (j > lo && hqs_pkg::lt(pivot, rd_data)) begin
            j <= j - 1'b1;
            state <= S_JRD;
          end else if (j <= i) begin
            push_left_done <= 1'b0;
            state <= S_PUSH;
          end else begin
            state <= S_SWAP1;
          end
        end
        S_SWAP1: state <= S_SWAP2;
        S_SWAP2: begin
          i <= i + 1'b1;
          j <= j - 1'b1;
          state <= S_IRD;
        end
        S_PUSH: begin
          if (st_we) sp <= sp + 1'b1;
          if (!push_left_done) push_left_done <= 1'b1;
          else state <= S_POP;
        end
        S_EMRD: begin
          out_valid <= 1'b1;
          state <= S_EMIT;
        end
        S_EMIT: if (!out_stall) begin
          if ({1'b0, ek} + 1'b1 == count) begin
            out_valid <= 1'b0;
            count <= '0;
            ovf   <= 1'b0;
            state <= S_LOAD;
          end else begin
            ek <= ek + 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_comb begin
    out_item.sorted_value = rd_data;
    out_item.final_res    = ({1'b0, ek} + 1'b1 == count);
    out_item.truncated    = ovf;
  end
endmodule

// ----- hdl/hqs_checker.sv -----
// Port-level checker for the quicksort sorter, bound to the top level.
// Depends on hqs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hqs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hqs_pkg::out_item_t out_item
);
  logic held, taken;

  assign held  = out_valid && out_stall;
  assign taken = out_valid && !out_stall;

  // no input is taken while results are on offer
  `CHK_IMPL(a_no_overlap, clk, rst, out_valid |-> in_stall, "input open during emission")
  // a stalled result holds
  `CHK_IMPL(a_hold, clk, rst, held |=> $stable(out_item) && out_valid, "held item moved")
  // after the final result the input reopens
  `CHK_IMPL(a_reopen, clk, rst, taken && out_item.final_res |=> !in_stall, "input not reopened")
  // reset leaves no result pending
  `CHK_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "result after reset")
endmodule

bind hoare_quicksort_sorter_unit hqs_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item));
